@@ src/tlvd_pkg.sv @@
package tlvd_pkg;

    localparam int HEADER_BYTES = 5;
    localparam int HDR_CNT_W    = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] MAX_LENGTH_RESET = 32'd32768;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = HDR_CNT_W'(HEADER_BYTES - 1);

    // configuration register indexes
    localparam logic CFG_ENABLE     = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_DROP   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  packet_type;
        logic [31:0] packet_length;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

endpackage

@@ src/tlvd_front.sv @@
module tlvd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic [31:0]       i_max_length,
    output logic              o_push,
    output tlvd_pkg::t_result o_result
);

    localparam logic [tlvd_pkg::HDR_CNT_W-1:0] HDR_CNT_W_ONE = tlvd_pkg::HDR_CNT_W'(1);

    tlvd_pkg::t_phase                     r_phase, n_phase;
    logic [tlvd_pkg::HDR_CNT_W-1:0]       r_hdr_cnt, n_hdr_cnt;
    logic [7:0]                           r_type, n_type;
    logic [31:0]                          r_length, n_length;
    logic [31:0]                          r_seen, n_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= tlvd_pkg::PH_HEADER;
            r_hdr_cnt <= '0;
            r_type    <= '0;
            r_length  <= '0;
            r_seen    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_type    <= n_type;
            r_length  <= n_length;
            r_seen    <= n_seen;
        end
    end

    always_comb begin
        logic [31:0] seen_inc;
        logic [31:0] shifted;
        seen_inc  = r_seen + 32'd1;
        shifted   = {r_length[23:0], i_byte};
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_type    = r_type;
        n_length  = r_length;
        n_seen    = r_seen;
        o_push    = 1'b0;
        o_result.kind          = tlvd_pkg::KIND_DATA;
        o_result.packet_type   = r_type;
        o_result.packet_length = r_length;
        o_result.data_byte     = i_byte;
        o_result.last          = 1'b0;
        if (i_take) begin
            case (r_phase)
                tlvd_pkg::PH_DATA: begin
                    n_seen = seen_inc;
                    o_push = 1'b1;
                    if (seen_inc >= r_length) begin
                        o_result.last = 1'b1;
                        n_phase       = tlvd_pkg::PH_HEADER;
                        n_hdr_cnt     = '0;
                    end
                end
                tlvd_pkg::PH_DROP: begin
                    n_seen = seen_inc;
                    if (seen_inc >= r_length) begin
                        n_phase   = tlvd_pkg::PH_HEADER;
                        n_hdr_cnt = '0;
                    end
                end
                default: begin
                    // header phase, unused code too
                    n_phase = tlvd_pkg::PH_HEADER;
                    if (r_hdr_cnt == '0) begin
                        n_type    = i_byte;
                        n_length  = '0;
                        n_hdr_cnt = HDR_CNT_W_ONE;
                    end else if (r_hdr_cnt < tlvd_pkg::HDR_LAST_IDX) begin
                        n_length  = shifted;
                        n_hdr_cnt = r_hdr_cnt + HDR_CNT_W_ONE;
                    end else begin
                        n_length  = shifted;
                        n_hdr_cnt = '0;
                        n_seen    = '0;
                        o_result.packet_length = shifted;
                        o_result.data_byte     = 8'd0;
                        if (shifted == 32'd0) begin
                            o_push        = 1'b1;
                            o_result.kind = tlvd_pkg::KIND_EMPTY;
                            o_result.last = 1'b1;
                        end else if (shifted > i_max_length) begin
                            o_push        = 1'b1;
                            o_result.kind = tlvd_pkg::KIND_OVERSIZE;
                            o_result.last = 1'b1;
                            n_phase       = tlvd_pkg::PH_DROP;
                        end else begin
                            n_phase = tlvd_pkg::PH_DATA;
                        end
                    end
                end
            endcase
        end
    end

endmodule

@@ src/tlvd_queue.sv @@
module tlvd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tlvd_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output tlvd_pkg::t_result o_data
);

    tlvd_pkg::t_result                 r_mem [tlvd_pkg::QUEUE_DEPTH];
    logic [tlvd_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [tlvd_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [tlvd_pkg::QCNT_W-1:0]       r_count, n_count;
    logic                              pop;

    localparam logic [tlvd_pkg::QPTR_W-1:0] PTR_LAST = tlvd_pkg::QPTR_W'(tlvd_pkg::QUEUE_DEPTH - 1);
    localparam logic [tlvd_pkg::QPTR_W-1:0] PTR_ONE  = tlvd_pkg::QPTR_W'(1);
    localparam logic [tlvd_pkg::QCNT_W-1:0] CNT_ONE  = tlvd_pkg::QCNT_W'(1);
    localparam logic [tlvd_pkg::QCNT_W-1:0] CNT_FULL = tlvd_pkg::QCNT_W'(tlvd_pkg::QUEUE_DEPTH);

    assign o_valid = (r_count != '0);
    assign o_space = (r_count != CNT_FULL);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;
        end
        if (i_push && !pop) begin
            n_count = r_count + CNT_ONE;
        end else if (pop && !i_push) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/tlvd_top_check_placeholder.sv @@
module tlvd_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_enable,
    output logic [31:0] o_max_length
);

    logic        r_enable;
    logic [31:0] r_max_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_max_length <= tlvd_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tlvd_pkg::CFG_ENABLE:     r_enable     <= i_cfg_wdata[0];
                tlvd_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_enable     = r_enable;
    assign o_max_length = r_max_length;

endmodule

@@ src/tlv_packet_deframer.sv @@
// TLV packet deframer.
// Input channel (i_valid / o_ready, i_rx_byte): one received byte per item.
// A frame is a type byte, a four-byte big-endian length, then the payload.
// Output channel (o_valid / i_ready): one result per payload byte (kind 0,
// tagged with type and length, last on the final byte), one result for an
// empty frame (kind 1) and one for a frame longer than max_length (kind 2),
// whose payload is then consumed without results.
// Configuration: i_cfg_we writes register i_cfg_addr (0 enable, 1 max_length)
// with i_cfg_wdata; while enable is low, bytes are taken and ignored.
// Throughput is one byte per cycle while the result queue has space; the header
// parser and the payload counter decide each byte in the cycle it is accepted.
// A result is registered in the result queue before it reaches the output.
// A two-entry result queue sits between parser and output: when the receiver
// stalls, the queue fills and o_ready drops once both entries are taken.
// Reset (synchronous, active low) empties the queue, returns the parser to the
// header phase, clears enable and sets max_length to 32768.
module tlv_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_packet_type,
    output logic [31:0] o_packet_length,
    output logic [7:0]  o_data_byte,
    output logic        o_last
);

    logic              enable;
    logic [31:0]       max_length;
    logic              take;
    logic              push;
    logic              space;
    tlvd_pkg::t_result front_res;
    tlvd_pkg::t_result head_res;

    tlvd_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_enable     (enable),
        .o_max_length (max_length)
    );

    assign o_ready = space;
    assign take    = i_valid && space && enable;

    tlvd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_byte       (i_rx_byte),
        .i_max_length (max_length),
        .o_push       (push),
        .o_result     (front_res)
    );

    tlvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (head_res)
    );

    assign o_kind          = head_res.kind;
    assign o_packet_type   = head_res.packet_type;
    assign o_packet_length = head_res.packet_length;
    assign o_data_byte     = head_res.data_byte;
    assign o_last          = head_res.last;

endmodule
